// ===== sv/lbf_pkg.sv =====
// Shared constants, codes and types of the learning bridge forwarder.
package lbf_pkg;

  // Table and field sizes.
  localparam int TABLE_ENTRIES = 64;
  localparam int MAX_PORTS     = 8;
  localparam int MAC_W         = 48;
  localparam int PORT_W        = 3;
  localparam int MASK_W        = 8;
  localparam int AGE_W         = 11;
  localparam int LIMIT_W       = 10;
  localparam int APORTS_W      = 4;
  localparam int CFG_W         = 10;
  localparam int CFG_IDX_W     = 1;

  // Count of active ports widened by one so the port count itself fits.
  localparam int CNT_W = $clog2(MAX_PORTS + 1);

  localparam logic [AGE_W-1:0]    AGE_MAX          = '1;
  localparam logic [LIMIT_W-1:0]  AGE_LIMIT_RST    = LIMIT_W'(300);
  localparam logic [APORTS_W-1:0] ACTIVE_PORTS_RST = APORTS_W'(MAX_PORTS);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_PORTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT    = 1'b1;

  // Item operation codes.
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Token that walks down the row of cells, gathering search results.
  typedef struct packed {
    logic              tok;
    logic              dhit;
    logic [PORT_W-1:0] dport;
    logic              shit;
    logic              ffound;
  } scan_t;

  // Item and control fields seen by every cell at once.
  typedef struct packed {
    logic               op;
    logic [MAC_W-1:0]   src;
    logic [MAC_W-1:0]   dst;
    logic [PORT_W-1:0]  port;
    logic [LIMIT_W-1:0] limit;
    logic               commit;
  } cmd_t;

endpackage

// ===== sv/learning_bridge_forwarder.sv =====
// Learning bridge forwarder: controller, configuration and the row of table cells.
//
// Each frame or tick item is taken on start while busy is low. A search token
// then walks the row of TABLE_ENTRIES cells, one cell per clock, and the result
// strobe out_valid is registered once it leaves the last cell; busy falls with
// the strobe, so no new item is taken before the last one's result. The
// destination lookup sees the table as it was before the source is learned. A
// new source address is written into the lowest free entry in the cycle of the
// result strobe. The result is shown for exactly one cycle and cannot be held
// off. Configuration must be written only while busy is low and no result is
// pending; the block itself does not enforce this.
module learning_bridge_forwarder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_operation,
  input  logic [lbf_pkg::MAC_W-1:0]    in_src_mac,
  input  logic [lbf_pkg::MAC_W-1:0]    in_dest_mac,
  input  logic [lbf_pkg::PORT_W-1:0]   in_in_port,
  output logic                         out_valid,
  output logic [lbf_pkg::MASK_W-1:0]   out_egress_mask,
  output logic                         out_flooded,
  output logic                         out_learn_dropped,
  input  logic                         cfg_we,
  input  logic [lbf_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [lbf_pkg::CFG_W-1:0]    cfg_wdata
);
  import lbf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t                state_r, state_nxt;
  logic                  launch_r, launch_nxt;
  logic                  commit_r, commit_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0]     mask_r, mask_nxt;
  logic                  flood_r, flood_nxt;
  logic                  drop_r, drop_nxt;
  logic [APORTS_W-1:0]   active_r;
  logic [LIMIT_W-1:0]    limit_r;
  logic                  op_r;
  logic [MAC_W-1:0]      src_r;
  logic [MAC_W-1:0]      dst_r;
  logic [PORT_W-1:0]     port_r;
  logic                  accept;
  cmd_t                  cmd;
  scan_t                 scan_w [TABLE_ENTRIES+1];
  scan_t                 last;
  logic [TABLE_ENTRIES-1:0] cand_vec;
  logic [CNT_W-1:0]      n_cnt;
  logic [MASK_W:0]       act_one;
  logic [MASK_W-1:0]     act_mask;
  logic [MASK_W-1:0]     in_bit;
  logic [MASK_W-1:0]     hit_bit;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // Item fields are broadcast to every cell while the token walks.
  always_comb begin
    cmd.op     = op_r;
    cmd.src    = src_r;
    cmd.dst    = dst_r;
    cmd.port   = port_r;
    cmd.limit  = limit_r;
    cmd.commit = commit_r;
  end

  // Token launch into the first cell; tok is the top bit of the token.
  assign scan_w[0] = scan_t'({launch_r, {($bits(scan_t) - 1){1'b0}}});

  // Row of table cells.
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    lbf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .scan_in  (scan_w[g]),
      .scan_out (scan_w[g+1]),
      .cand     (cand_vec[g])
    );
  end

  assign last = scan_w[TABLE_ENTRIES];

  // Active port mask, with the port count clamped to 1..MAX_PORTS.
  always_comb begin
    if (active_r == '0) begin
      n_cnt = CNT_W'(1);
    end else if (CNT_W'(active_r) > CNT_W'(MAX_PORTS)) begin
      n_cnt = CNT_W'(MAX_PORTS);
    end else begin
      n_cnt = CNT_W'(active_r);
    end
    act_one  = (MASK_W+1)'(1) << n_cnt;
    act_mask = MASK_W'(act_one - (MASK_W+1)'(1));
    in_bit   = MASK_W'(1) << port_r;
    hit_bit  = MASK_W'(1) << last.dport;
  end

  // Sequencing and the forwarding decision at the end of the row.
  always_comb begin
    state_nxt     = state_r;
    launch_nxt    = 1'b0;
    commit_nxt    = 1'b0;
    out_valid_nxt = 1'b0;
    mask_nxt      = mask_r;
    flood_nxt     = flood_r;
    drop_nxt      = drop_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt  = ST_SCAN;
          launch_nxt = 1'b1;
        end
      end
      ST_SCAN: begin
        if (last.tok) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          mask_nxt      = '0;
          flood_nxt     = 1'b0;
          drop_nxt      = 1'b0;
          if (op_r == OP_FRAME) begin
            if (!last.dhit) begin
              mask_nxt  = act_mask & ~in_bit;
              flood_nxt = 1'b1;
            end else if (last.dport != port_r) begin
              mask_nxt = hit_bit & act_mask;
            end
            if (!last.shit) begin
              commit_nxt = last.ffound;
              drop_nxt   = !last.ffound;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launch_r    <= 1'b0;
      commit_r    <= 1'b0;
      out_valid_r <= 1'b0;
      active_r    <= ACTIVE_PORTS_RST;
      limit_r     <= AGE_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      commit_r    <= commit_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_ACTIVE_PORTS: active_r <= cfg_wdata[APORTS_W-1:0];
          CFG_AGE_LIMIT:    limit_r  <= cfg_wdata[LIMIT_W-1:0];
          default:          active_r <= active_r;
        endcase
      end
    end
  end

  // Item and result payload.
  always_ff @(posedge clk) begin
    mask_r  <= mask_nxt;
    flood_r <= flood_nxt;
    drop_r  <= drop_nxt;
    if (accept) begin
      op_r   <= in_operation;
      src_r  <= in_src_mac;
      dst_r  <= in_dest_mac;
      port_r <= in_in_port;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_egress_mask   = mask_r;
  assign out_flooded       = flood_r;
  assign out_learn_dropped = drop_r;

`ifndef SYNTHESIS
  // At most one cell holds the claim on the free slot.
  a_one_cand: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cand_vec))
    else $error("more than one cell claims the free slot");

  // A commit always has exactly one claimed cell to write.
  a_commit_cand: assert property (@(posedge clk) disable iff (!rst_n)
    commit_r |-> $onehot(cand_vec))
    else $error("commit without a claimed free cell");

  // A commit only follows the end of a frame scan, with its result strobe.
  a_commit_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    commit_r |-> out_valid_r && (op_r == OP_FRAME) && !drop_r)
    else $error("commit without a matching frame result");

  // The token is only in the row while an item is being worked on.
  a_tok_busy: assert property (@(posedge clk) disable iff (!rst_n)
    last.tok |-> (state_r == ST_SCAN))
    else $error("search token outside of a scan");

  // A tick item never forwards or drops anything.
  a_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (op_r == OP_TICK)) |-> (mask_r == '0) && !flood_r && !drop_r)
    else $error("tick item produced a forwarding result");
`endif

endmodule

// ===== sv/lbf_cell.sv =====
// One table entry of the bridge: lookup, refresh, aging and free-slot claim.
module lbf_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  lbf_pkg::cmd_t  cmd,
  input  lbf_pkg::scan_t scan_in,
  output lbf_pkg::scan_t scan_out,
  output logic           cand
);
  import lbf_pkg::*;

  logic               valid_r, valid_nxt;
  logic               cand_r, cand_nxt;
  logic [MAC_W-1:0]   mac_r, mac_nxt;
  logic [PORT_W-1:0]  port_r, port_nxt;
  logic [AGE_W-1:0]   age_r, age_nxt;
  scan_t              scan_r, scan_nxt;
  logic               frame;
  logic               dmatch;
  logic               smatch;
  logic [AGE_W-1:0]   aged;

  assign frame  = (cmd.op == OP_FRAME);
  assign dmatch = valid_r && (mac_r == cmd.dst);
  assign smatch = valid_r && (mac_r == cmd.src);
  assign aged   = (age_r < AGE_MAX) ? age_r + AGE_W'(1) : age_r;

  // Fold this entry into the token, using the entry as it was before this item.
  always_comb begin
    scan_nxt        = scan_in;
    scan_nxt.dhit   = scan_in.dhit || (frame && dmatch);
    scan_nxt.dport  = (!scan_in.dhit && dmatch) ? port_r : scan_in.dport;
    scan_nxt.shit   = scan_in.shit || (frame && smatch);
    scan_nxt.ffound = scan_in.ffound || !valid_r;
  end

  // Entry update while the token passes, or when a new address is committed.
  always_comb begin
    valid_nxt = valid_r;
    cand_nxt  = cand_r;
    mac_nxt   = mac_r;
    port_nxt  = port_r;
    age_nxt   = age_r;
    if (scan_in.tok) begin
      if (frame) begin
        cand_nxt = !valid_r && !scan_in.ffound;
        if (smatch) begin
          port_nxt = cmd.port;
          age_nxt  = '0;
        end
      end else begin
        cand_nxt = 1'b0;
        if (valid_r) begin
          age_nxt = aged;
          if (aged > AGE_W'(cmd.limit)) begin
            valid_nxt = 1'b0;
          end
        end
      end
    end else if (cmd.commit && cand_r) begin
      valid_nxt = 1'b1;
      cand_nxt  = 1'b0;
      mac_nxt   = cmd.src;
      port_nxt  = cmd.port;
      age_nxt   = '0;
    end
  end

  // Control state is reset; entry contents and token results are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      cand_r     <= 1'b0;
      scan_r.tok <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      cand_r     <= cand_nxt;
      scan_r.tok <= scan_nxt.tok;
    end
    mac_r         <= mac_nxt;
    port_r        <= port_nxt;
    age_r         <= age_nxt;
    scan_r.dhit   <= scan_nxt.dhit;
    scan_r.dport  <= scan_nxt.dport;
    scan_r.shit   <= scan_nxt.shit;
    scan_r.ffound <= scan_nxt.ffound;
  end

  assign scan_out = scan_r;
  assign cand     = cand_r;

endmodule

// ===== dv/lbf_forward_checker.sv =====
// Checker of the learning bridge forwarder: predicts each forwarding decision and compares it.
`timescale 1ns / 1ps

module lbf_forward_checker
  import lbf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 in_operation,
  input  logic [MAC_W-1:0]     in_src_mac,
  input  logic [MAC_W-1:0]     in_dest_mac,
  input  logic [PORT_W-1:0]    in_in_port,
  input  logic                 out_valid,
  input  logic [MASK_W-1:0]    out_egress_mask,
  input  logic                 out_flooded,
  input  logic                 out_learn_dropped,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   decisions_pending
);

  typedef struct packed {
    logic [MASK_W-1:0] egress_mask;
    logic              flooded;
    logic              learn_dropped;
  } decision_t;

  // Expected forwarding decisions, oldest first.
  decision_t decisions_q[$];

  // Shadow copy of the address table and of the configuration.
  logic               tbl_valid [TABLE_ENTRIES];
  logic [MAC_W-1:0]   tbl_mac   [TABLE_ENTRIES];
  logic [PORT_W-1:0]  tbl_port  [TABLE_ENTRIES];
  logic [AGE_W-1:0]   tbl_age   [TABLE_ENTRIES];
  logic [APORTS_W-1:0] act_ports;
  logic [LIMIT_W-1:0]  age_lim;

  function automatic int find_entry(logic [MAC_W-1:0] mac);
    int idx;
    idx = -1;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_mac[i] == mac) idx = i;
    end
    return idx;
  endfunction

  // Forwarding decision for one item, then learning or aging of the table.
  function automatic decision_t forward_and_learn(logic op, logic [MAC_W-1:0] src,
                                                  logic [MAC_W-1:0] dst,
                                                  logic [PORT_W-1:0] port);
    decision_t d;
    int        n;
    int        idx;
    logic [MASK_W-1:0] act;
    d = '0;
    if (op == OP_TICK) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (tbl_valid[i]) begin
          if (tbl_age[i] != AGE_MAX) tbl_age[i] = tbl_age[i] + 1'b1;
          if (tbl_age[i] > age_lim) tbl_valid[i] = 1'b0;
        end
      end
    end else begin
      n = act_ports;
      if (n < 1) n = 1;
      if (n > MAX_PORTS) n = MAX_PORTS;
      act = MASK_W'((1 << n) - 1);
      // The lookup sees the table before the source is learned.
      idx = find_entry(dst);
      if (idx < 0) begin
        d.egress_mask = act & ~(MASK_W'(1) << port);
        d.flooded     = 1'b1;
      end else if (tbl_port[idx] != port) begin
        d.egress_mask = (MASK_W'(1) << tbl_port[idx]) & act;
      end
      // Refresh a known source, else take the lowest free entry.
      idx = find_entry(src);
      for (int i = 0; i < TABLE_ENTRIES && idx < 0; i++) begin
        if (!tbl_valid[i]) idx = i;
      end
      if (idx >= 0) begin
        tbl_valid[idx] = 1'b1;
        tbl_mac[idx]   = src;
        tbl_port[idx]  = port;
        tbl_age[idx]   = '0;
      end else begin
        d.learn_dropped = 1'b1;
      end
    end
    return d;
  endfunction

  always @(posedge clk) begin
    decision_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) tbl_valid[i] = 1'b0;
      act_ports = ACTIVE_PORTS_RST;
      age_lim   = AGE_LIMIT_RST;
      decisions_q.delete();
      fail_count = 0;
    end else begin
      // Compare a strobed result with the oldest expectation.
      if (out_valid) begin
        if (decisions_q.size() == 0) begin
          $error("result strobe with no item outstanding");
          fail_count++;
        end else begin
          want = decisions_q.pop_front();
          if (out_egress_mask !== want.egress_mask) begin
            $error("egress_mask: expected %02h, actual %02h",
                   want.egress_mask, out_egress_mask);
            fail_count++;
          end
          if (out_flooded !== want.flooded) begin
            $error("flooded: expected %0b, actual %0b", want.flooded, out_flooded);
            fail_count++;
          end
          if (out_learn_dropped !== want.learn_dropped) begin
            $error("learn_dropped: expected %0b, actual %0b",
                   want.learn_dropped, out_learn_dropped);
            fail_count++;
          end
        end
      end
      // Track register writes.
      if (cfg_we) begin
        case (cfg_idx)
          CFG_ACTIVE_PORTS: act_ports = cfg_wdata[APORTS_W-1:0];
          CFG_AGE_LIMIT:    age_lim   = cfg_wdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
      // Predict every accepted item.
      if (start && !busy) begin
        decisions_q.push_back(forward_and_learn(in_operation, in_src_mac,
                                                in_dest_mac, in_in_port));
      end
    end
    decisions_pending = decisions_q.size();
  end

endmodule

// ===== dv/tb_learning_bridge_forwarder.sv =====
// Testbench top of the learning bridge forwarder: stimulus, timeout and verdict.
`timescale 1ns / 1ps

module tb_learning_bridge_forwarder;
  import lbf_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int POOL_SIZE   = 128;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_operation;
  logic [MAC_W-1:0]     in_src_mac;
  logic [MAC_W-1:0]     in_dest_mac;
  logic [PORT_W-1:0]    in_in_port;
  logic                 out_valid;
  logic [MASK_W-1:0]    out_egress_mask;
  logic                 out_flooded;
  logic                 out_learn_dropped;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   fail_count;
  int                   decisions_pending;
  int                   cycle_count = 0;

  // Addresses reused across items so that lookups hit and the table fills.
  logic [MAC_W-1:0] mac_pool [POOL_SIZE];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  learning_bridge_forwarder u_dut (
    .clk, .rst_n, .start, .busy, .in_operation, .in_src_mac, .in_dest_mac,
    .in_in_port, .out_valid, .out_egress_mask, .out_flooded, .out_learn_dropped,
    .cfg_we, .cfg_idx, .cfg_wdata
  );

  lbf_forward_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_operation, .in_src_mac, .in_dest_mac,
    .in_in_port, .out_valid, .out_egress_mask, .out_flooded, .out_learn_dropped,
    .cfg_we, .cfg_idx, .cfg_wdata, .fail_count, .decisions_pending
  );

  // The run ends here if the block stops answering.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("learning_bridge_forwarder verification failed");
      $finish;
    end
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  // Offer one item at a falling edge and hold it until the block takes it.
  task automatic send_item(logic op, logic [MAC_W-1:0] src, logic [MAC_W-1:0] dst,
                           logic [PORT_W-1:0] port);
    logic taken;
    start        <= 1'b1;
    in_operation <= op;
    in_src_mac   <= src;
    in_dest_mac  <= dst;
    in_in_port   <= port;
    taken = 1'b0;
    while (!taken) begin
      // busy only moves on a rising edge, so its mid-cycle value decides.
      taken = !busy;
      @(negedge clk);
    end
  endtask

  task automatic frame(logic [MAC_W-1:0] src, logic [MAC_W-1:0] dst,
                       logic [PORT_W-1:0] port);
    send_item(OP_FRAME, src, dst, port);
  endtask

  task automatic tick();
    send_item(OP_TICK, rand_mac(), rand_mac(), PORT_W'($urandom()));
  endtask

  // Stop sending and wait until every expected result has come.
  task automatic drain();
    start <= 1'b0;
    while (decisions_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write both registers while the block is idle.
  task automatic set_config(logic [APORTS_W-1:0] ports, logic [LIMIT_W-1:0] limit);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_ACTIVE_PORTS;
    cfg_wdata <= CFG_W'(ports);
    @(negedge clk);
    cfg_idx   <= CFG_AGE_LIMIT;
    cfg_wdata <= CFG_W'(limit);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random items drawn mostly from a pool of addresses of the given size.
  task automatic run_phase(int items, int idle_pct, int pool_sz);
    logic [MAC_W-1:0] src;
    logic [MAC_W-1:0] dst;
    for (int k = 0; k < items; k++) begin
      if ($urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 80)) @(negedge clk);
      end else if ($urandom_range(0, 59) == 0) begin
        drain();
      end
      if ($urandom_range(0, 9) == 0) begin
        tick();
      end else begin
        src = ($urandom_range(0, 19) == 0) ? rand_mac()
                                           : mac_pool[$urandom_range(0, pool_sz - 1)];
        dst = ($urandom_range(0, 4) == 0) ? rand_mac()
                                          : mac_pool[$urandom_range(0, pool_sz - 1)];
        frame(src, dst, PORT_W'($urandom()));
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = OP_FRAME;
    in_src_mac   = '0;
    in_dest_mac  = '0;
    in_in_port   = '0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_ACTIVE_PORTS;
    cfg_wdata    = '0;
    mac_pool[0] = '0;
    mac_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) mac_pool[i] = rand_mac();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: address extremes, hits, misses and the source-equals-destination case.
    set_config(4'd8, 10'd300);
    frame('0, '1, 3'd0);
    frame('1, '0, 3'd7);
    frame(mac_pool[2], mac_pool[2], 3'd3);
    frame(mac_pool[2], mac_pool[2], 3'd3);
    frame(mac_pool[3], mac_pool[2], 3'd5);
    send_item(OP_TICK, '1, '1, 3'd7);
    frame(mac_pool[4], mac_pool[3], 3'd7);

    // Learned port and ingress port outside the active range.
    set_config(4'd2, 10'd300);
    frame(mac_pool[4], mac_pool[3], 3'd1);
    frame(rand_mac(), rand_mac(), 3'd6);
    frame(mac_pool[2], mac_pool[4], 3'd0);

    // Port count of zero counts as one, above the maximum counts as the maximum.
    set_config(4'd0, 10'd300);
    frame(rand_mac(), rand_mac(), 3'd1);
    frame(rand_mac(), rand_mac(), 3'd0);
    set_config(4'd15, 10'd1);
    frame(rand_mac(), rand_mac(), 3'd4);

    // Expiry after the limit, and a limit of zero that clears at the first tick.
    tick();
    frame(rand_mac(), mac_pool[2], 3'd2);
    tick();
    frame(rand_mac(), mac_pool[2], 3'd2);
    set_config(4'd8, 10'd0);
    frame(mac_pool[2], mac_pool[3], 3'd3);
    tick();
    frame(mac_pool[3], mac_pool[2], 3'd4);

    // Random phases: sender gaps at 14 percent, then 47 percent, then none.
    set_config(4'd8, 10'd1023);
    run_phase(272, 14, 100);
    set_config(4'd1, 10'd1);
    run_phase(272, 14, 40);
    set_config(4'd15, 10'd0);
    run_phase(272, 47, 40);
    set_config(4'd4, 10'd3);
    run_phase(272, 47, 70);
    set_config(4'd0, 10'd20);
    run_phase(272, 0, 90);
    set_config(4'd6, 10'd300);
    run_phase(272, 0, 64);

    drain();
    repeat (70) @(negedge clk);
    if (fail_count == 0) begin
      $display("learning_bridge_forwarder verification clean");
    end else begin
      $display("learning_bridge_forwarder verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/lbf_pkg.sv
sv/lbf_cell.sv
sv/learning_bridge_forwarder.sv
dv/lbf_forward_checker.sv
dv/tb_learning_bridge_forwarder.sv
